// ----- design/mppd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mppd_pkg: shared definitions for the magnetic probe pointer delta block
// Register map, reset values, configuration struct and back-end states.
// ---------------------------------------------------------------------------
package mppd_pkg;

  localparam int SAMPLE_BITS_DEFAULT   = 16;
  localparam int FRACTION_BITS_DEFAULT = 12;

  localparam int THRESHOLD_W = 15;
  localparam int GAIN_W      = 8;
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN      = 1'b1;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 15'd1229;
  localparam logic [GAIN_W-1:0]      GAIN_RESET      = 8'd50;

  typedef struct packed {
    logic [THRESHOLD_W-1:0] threshold;
    logic [GAIN_W-1:0]      gain;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROOT,
    B_FACTOR,
    B_MUL_X,
    B_MUL_Y,
    B_SAT_Y,
    B_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ----- design/mppd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mppd_queue: two-entry queue between front and back
// Decouples classification from the scaling sequencer.
// ---------------------------------------------------------------------------
module mppd_queue #(
  parameter int WIDTH = 50
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  push_ready,
  output logic                  pop_valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && pop_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && push_ready, pop && pop_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- design/mppd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mppd_front: sample intake and classification
// Registers a sample, forms the mirrored delta magnitudes and the depth,
// drops samples with no probe present and queues the rest.
// ---------------------------------------------------------------------------
module mppd_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mppd_pkg::cfg_t                cfg,
  input  wire logic                          sample_valid,
  output logic                               sample_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] field_x,
  input  wire logic signed [SAMPLE_BITS-1:0] field_y,
  input  wire logic signed [SAMPLE_BITS-1:0] field_z,
  output logic                               push,
  input  wire logic                          push_ready,
  output logic [3*SAMPLE_BITS+1:0]           entry
);
  import mppd_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int CW = (S > THRESHOLD_W) ? S : THRESHOLD_W;

  logic                stage_valid;
  logic signed [S-1:0] sx;
  logic signed [S-1:0] sy;
  logic signed [S-1:0] sz;
  logic signed [S-1:0] prev_x;
  logic signed [S-1:0] prev_y;

  logic          ge_x, ge_y, zneg, present, retire;
  logic [S:0]    dx_a, dx_b, dy_a, dy_b;
  logic [S-1:0]  mag_x, mag_y, absz, depth;
  logic [CW-1:0] absz_w, thr_w, depth_w;

  always_comb begin
    // Magnitude of each delta from two parallel subtracts
    ge_x  = (sx >= prev_x);
    ge_y  = (sy >= prev_y);
    dx_a  = {sx[S-1], sx} - {prev_x[S-1], prev_x};
    dx_b  = {prev_x[S-1], prev_x} - {sx[S-1], sx};
    dy_a  = {sy[S-1], sy} - {prev_y[S-1], prev_y};
    dy_b  = {prev_y[S-1], prev_y} - {sy[S-1], sy};
    mag_x = ge_x ? dx_a[S-1:0] : dx_b[S-1:0];
    mag_y = ge_y ? dy_a[S-1:0] : dy_b[S-1:0];

    // Most negative Z gives exactly half range, held unsigned
    zneg    = sz[S-1];
    absz    = zneg ? (~sz + 1'b1) : sz;
    absz_w  = CW'(absz);
    thr_w   = CW'(cfg.threshold);
    present = (absz_w > thr_w);
    depth_w = absz_w - thr_w;
    depth   = depth_w[S-1:0];

    retire       = stage_valid && (!present || push_ready);
    push         = stage_valid && present && push_ready;
    sample_ready = !stage_valid || retire;
    // A mirrored delta flips sign
    entry = {(!ge_x) ^ zneg, mag_x, (!ge_y) ^ zneg, mag_y, depth};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      prev_x      <= '0;
      prev_y      <= '0;
    end else begin
      if (retire) begin
        prev_x <= sx;
        prev_y <= sy;
      end
      if (sample_ready) begin
        stage_valid <= sample_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      sx <= field_x;
      sy <= field_y;
      sz <= field_z;
    end
  end

endmodule
`default_nettype wire

// ----- design/mppd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mppd_back: depth scaling sequencer
// Bit-per-cycle square root of the depth, gain multiply, one shared delta
// multiplier, truncation and saturation, and the result register.
// ---------------------------------------------------------------------------
module mppd_back #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mppd_pkg::cfg_t             cfg,
  input  wire logic                       pop_valid,
  output logic                            pop_ready,
  input  wire logic [3*SAMPLE_BITS+1:0]   entry,
  output logic                            move_valid,
  input  wire logic                       move_ready,
  output logic signed [SAMPLE_BITS-1:0]   move_x,
  output logic signed [SAMPLE_BITS-1:0]   move_y
);
  import mppd_pkg::*;

  localparam int S     = SAMPLE_BITS;
  localparam int F     = FRACTION_BITS;
  localparam int RW    = (S + F + 1) / 2;
  localparam int RAD_W = 2 * RW;
  localparam int REM_W = RW + 2;
  localparam int CNT_W = $clog2(RW);
  localparam int FW    = RW + GAIN_W;
  localparam int PW    = S + FW;
  localparam int PWE   = (PW > 65) ? PW : 65;
  localparam logic [PWE-1:0] HALF    = {{(PWE-1){1'b0}}, 1'b1} << (S - 1);
  localparam logic [PWE-1:0] HALF_M1 = HALF - 1'b1;

  back_state_t state, state_next;

  logic             neg_x, neg_y;
  logic [S-1:0]     mag_x, mag_y;
  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [RW-1:0]    root;
  logic [CNT_W-1:0] cnt;
  logic [FW-1:0]    factor;
  logic [PW-1:0]    prod;
  logic [S-1:0]     res_x, res_y;

  logic [REM_W+1:0] acc, trial, diff;
  logic             take, res_nz, load_out;

  function automatic logic [S-1:0] scale(input logic neg, input logic [PW-1:0] p);
    logic [PWE-1:0] pe;
    logic [PWE-1:0] q;
    logic           ovf;
    logic [S-1:0]   qs;
    pe  = PWE'(p);
    ovf = |pe[PWE-1:64];
    q   = pe >> (2 * F);
    if (neg) begin
      qs    = (ovf || q > HALF) ? HALF[S-1:0] : q[S-1:0];
      scale = ~qs + 1'b1;
    end else begin
      qs    = (ovf || q > HALF_M1) ? HALF_M1[S-1:0] : q[S-1:0];
      scale = qs;
    end
  endfunction

  // One root bit per step: bring down two radicand bits, trial subtract
  always_comb begin
    acc   = {rem, rad[RAD_W-1 -: 2]};
    trial = (REM_W+2)'({root, 2'b01});
    take  = (acc >= trial);
    diff  = acc - trial;
  end

  assign res_nz = (res_x != '0) || (res_y != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    load_out   = 1'b0;
    case (state)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = B_ROOT;
        end
      end
      B_ROOT: begin
        if (cnt == '0) begin
          state_next = B_FACTOR;
        end
      end
      B_FACTOR: state_next = B_MUL_X;
      B_MUL_X:  state_next = B_MUL_Y;
      B_MUL_Y:  state_next = B_SAT_Y;
      B_SAT_Y:  state_next = B_EMIT;
      B_EMIT: begin
        // Drop a move that came out zero on both axes
        if (!res_nz) begin
          state_next = B_IDLE;
        end else if (!move_valid || move_ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop_valid) begin
          {neg_x, mag_x, neg_y, mag_y} <= entry[3*S+1:S];
          rad  <= RAD_W'({entry[S-1:0], {F{1'b0}}});
          rem  <= '0;
          root <= '0;
          cnt  <= CNT_W'(RW - 1);
        end
      end
      B_ROOT: begin
        rad  <= rad << 2;
        rem  <= take ? diff[REM_W-1:0] : acc[REM_W-1:0];
        root <= {root[RW-2:0], take};
        cnt  <= cnt - 1'b1;
      end
      B_FACTOR: factor <= FW'(root) * FW'(cfg.gain);
      B_MUL_X:  prod   <= PW'(mag_x) * PW'(factor);
      B_MUL_Y: begin
        res_x <= scale(neg_x, prod);
        prod  <= PW'(mag_y) * PW'(factor);
      end
      B_SAT_Y: res_y <= scale(neg_y, prod);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      move_valid <= 1'b0;
    end else if (load_out) begin
      move_valid <= 1'b1;
    end else if (move_ready) begin
      move_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      move_x <= res_x;
      move_y <= res_y;
    end
  end

endmodule
`default_nettype wire

// ----- design/magnetic_probe_pointer_delta.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// magnetic_probe_pointer_delta: magnetometer sample to relative pointer move
// Front stage classifies samples, a two-entry queue feeds the scaling
// sequencer, which emits a saturated move when either axis is nonzero.
//
//   channel  | signals                             | role
//   ---------+-------------------------------------+-------------------------
//   sample   | sample_valid/ready, field_x/y/z     | magnetometer sample in
//   move     | move_valid/ready, move_x/y          | relative move out
//   config   | cfg_write, cfg_index, cfg_data      | register write, no wait
//
// A sample is registered in the front stage; samples with no probe present
// retire there at one per cycle. A present sample holds the back sequencer
// through its square root (one bit per cycle), factor, X multiply, Y multiply,
// Y saturate and emit states; in emit the move waits until the result
// register is free. The queue and the result register let the front keep
// taking samples while a move waits. Reset is synchronous and clears the
// previous X and Y, the registers to their defaults and all valid flags.
// ---------------------------------------------------------------------------
module magnetic_probe_pointer_delta #(
  parameter int SAMPLE_BITS   = mppd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int FRACTION_BITS = mppd_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [mppd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [mppd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                  sample_valid,
  output logic                                       sample_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]         field_x,
  input  wire logic signed [SAMPLE_BITS-1:0]         field_y,
  input  wire logic signed [SAMPLE_BITS-1:0]         field_z,
  output logic                                       move_valid,
  input  wire logic                                  move_ready,
  output logic signed [SAMPLE_BITS-1:0]              move_x,
  output logic signed [SAMPLE_BITS-1:0]              move_y
);
  import mppd_pkg::*;

  localparam int ENTRY_W = 3 * SAMPLE_BITS + 2;

  cfg_t               cfg;
  logic               q_push, q_space, q_valid, q_pop;
  logic [ENTRY_W-1:0] q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RESET;
      cfg.gain      <= GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: cfg.threshold <= cfg_data[THRESHOLD_W-1:0];
        REG_GAIN:      cfg.gain      <= cfg_data[GAIN_W-1:0];
        default:       ;
      endcase
    end
  end

  mppd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .field_x      (field_x),
    .field_y      (field_y),
    .field_z      (field_z),
    .push         (q_push),
    .push_ready   (q_space),
    .entry        (q_in)
  );

  mppd_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_space),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_out)
  );

  mppd_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .entry      (q_out),
    .move_valid (move_valid),
    .move_ready (move_ready),
    .move_x     (move_x),
    .move_y     (move_y)
  );

  a_no_zero_move: assert property (@(posedge clk) disable iff (rst)
    move_valid |-> (move_x != '0 || move_y != '0))
    else $error("zero move presented");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && !q_space))
    else $error("front pushed into a full queue");

  a_gain_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index == REG_GAIN) |=> (cfg.gain == $past(cfg_data[GAIN_W-1:0])))
    else $error("gain register did not take the write");

endmodule
`default_nettype wire
